FILE: design/cmc_pkg.sv
// cmc_pkg: shared constants and the request type for the color matrix concat block
// used by cmc_front, cmc_queue, cmc_back and color_matrix_concat
`default_nettype none
package cmc_pkg;
	localparam int ENTRIES       = 20;
	localparam int ROW_LEN       = 5;
	localparam int TERMS         = 4;
	localparam int FRAC_BITS_DEF = 16;
	localparam int IDX_W         = 5;
	localparam int VAL_W         = 32;
	localparam int TDATA_W       = 40;
	localparam int TUSER_W       = 2;
	localparam int ACC_W         = 64;
	localparam int QDEPTH        = 4;

	typedef struct packed {
		logic              which;
		logic [IDX_W-1:0]  index;
		logic [VAL_W-1:0]  value;
		logic              compute;
		logic              index_ok;
	} cmd_t;
endpackage
`default_nettype wire

FILE: design/cmc_front.sv
// cmc_front: input register stage, unpacks and classifies each request
// depends on cmc_pkg; feeds cmc_queue
`default_nettype none
module cmc_front import cmc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [TDATA_W-1:0] s_tdata,  // entry_index, entry_value
	input  wire logic [TUSER_W-1:0] s_tuser,  // which_matrix, compute
	output logic                    push,
	output cmd_t                    cmd,
	input  wire logic               full
);
	logic valid_q;
	cmd_t cmd_q;

	assign push     = valid_q && !full;
	assign s_tready = !valid_q || !full;
	assign cmd      = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_q.which    <= s_tuser[0];
			cmd_q.compute  <= s_tuser[1];
			cmd_q.index    <= s_tdata[IDX_W-1:0];
			cmd_q.value    <= s_tdata[IDX_W+VAL_W-1:IDX_W];
			cmd_q.index_ok <= (s_tdata[IDX_W-1:0] < IDX_W'(ENTRIES));
		end
	end
endmodule
`default_nettype wire

FILE: design/cmc_queue.sv
// cmc_queue: short request queue between front and back
// depends on cmc_pkg
`default_nettype none
module cmc_queue import cmc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output cmd_t      head,
	output logic      not_empty
);
	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	cmd_t             slot_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end
endmodule
`default_nettype wire

FILE: design/cmc_back.sv
// cmc_back: matrix stores, product sequencer, multiply-accumulate pipe, output register
// depends on cmc_pkg; takes requests from cmc_queue
`default_nettype none
module cmc_back import cmc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               head,
	input  wire logic               not_empty,
	output logic                    pop,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,  // result_index, result_value
	output logic                    m_tlast
);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;
	localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'h0000_0000_7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

	typedef struct packed {
		logic             first;
		logic             fin;
		logic             col_last;
		logic [IDX_W-1:0] ent;
	} tag_t;

	logic             state_q;
	logic [IDX_W-1:0] row_base_q;
	logic [IDX_W-1:0] k_base_q;
	logic [2:0]       col_q;
	logic [2:0]       k_q;
	logic [IDX_W-1:0] ent_q;

	logic [VAL_W-1:0] outer_mem [ENTRIES];
	logic [VAL_W-1:0] inner_mem [ENTRIES];

	logic                     stall;
	logic                     issue;
	logic                     last_k;
	logic [IDX_W-1:0]         outer_addr;
	logic [IDX_W-1:0]         inner_addr;

	logic                     v_s1, v_s2, v_s3;
	tag_t                     tag_s1, tag_s2, tag_s3;
	logic signed [VAL_W-1:0]  a_s1, b_s1;
	logic signed [VAL_W-1:0]  outer_s2;
	logic signed [ACC_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]  term_s3;
	logic signed [ACC_W-1:0]  rnd;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_next;

	logic                     o_valid_q;
	logic [IDX_W-1:0]         o_index_q;
	logic [VAL_W-1:0]         o_value_q;
	logic                     o_last_q;

	assign stall      = o_valid_q && !m_tready;
	assign pop        = (state_q == ST_IDLE) && not_empty;
	assign issue      = (state_q == ST_RUN) && !stall;
	assign last_k     = (k_q == 3'(TERMS));
	assign outer_addr = row_base_q + IDX_W'(k_q);
	assign inner_addr = last_k ? '0 : k_base_q + IDX_W'(col_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			row_base_q <= '0;
			k_base_q   <= '0;
			col_q      <= '0;
			k_q        <= '0;
			ent_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop && head.compute) begin
						state_q    <= ST_RUN;
						row_base_q <= '0;
						k_base_q   <= '0;
						col_q      <= '0;
						k_q        <= '0;
						ent_q      <= '0;
					end
				end
				ST_RUN: begin
					if (issue) begin
						if (last_k) begin
							k_q      <= '0;
							k_base_q <= '0;
							ent_q    <= ent_q + 1'b1;
							if (col_q == 3'(ROW_LEN - 1)) begin
								col_q      <= '0;
								row_base_q <= row_base_q + IDX_W'(ROW_LEN);
							end else begin
								col_q <= col_q + 1'b1;
							end
							if (ent_q == IDX_W'(ENTRIES - 1)) begin
								state_q <= ST_IDLE;
								ent_q   <= '0;
							end
						end else begin
							k_q      <= k_q + 1'b1;
							k_base_q <= k_base_q + IDX_W'(ROW_LEN);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// matrix stores
	always_ff @(posedge clk) begin
		if (pop && head.index_ok) begin
			if (head.which) begin
				inner_mem[head.index] <= head.value;
			end else begin
				outer_mem[head.index] <= head.value;
			end
		end
		if (issue) begin
			a_s1 <= outer_mem[outer_addr];
			b_s1 <= inner_mem[inner_addr];
		end
	end

	// pipe valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign rnd = (prod_s2 + HALF) >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (!stall) begin
			tag_s1.first    <= (k_q == '0);
			tag_s1.fin      <= last_k;
			tag_s1.col_last <= (col_q == 3'(ROW_LEN - 1));
			tag_s1.ent      <= ent_q;
			tag_s2          <= tag_s1;
			prod_s2         <= a_s1 * b_s1;
			outer_s2        <= a_s1;
			tag_s3          <= tag_s2;
			if (!tag_s2.fin) begin
				term_s3 <= rnd;
			end else if (tag_s2.col_last) begin
				term_s3 <= ACC_W'(outer_s2);
			end else begin
				term_s3 <= '0;
			end
			if (v_s3) begin
				acc_q <= acc_next;
			end
		end
	end

	assign acc_next = (tag_s3.first ? '0 : acc_q) + term_s3;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (!stall && v_s3 && tag_s3.fin) begin
			o_valid_q <= 1'b1;
		end else if (m_tready) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && v_s3 && tag_s3.fin) begin
			o_index_q <= tag_s3.ent;
			o_last_q  <= (tag_s3.ent == IDX_W'(ENTRIES - 1));
			if (acc_next > SAT_MAX) begin
				o_value_q <= SAT_MAX[VAL_W-1:0];
			end else if (acc_next < SAT_MIN) begin
				o_value_q <= SAT_MIN[VAL_W-1:0];
			end else begin
				o_value_q <= acc_next[VAL_W-1:0];
			end
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = {(TDATA_W - IDX_W - VAL_W)'(0), o_value_q, o_index_q};
	assign m_tlast  = o_last_q;

`ifndef ASSERT_OFF
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == ST_IDLE)
		else $error("request taken while a product is running");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		issue && last_k && ent_q == IDX_W'(ENTRIES - 1) |=> state_q == ST_IDLE)
		else $error("sequencer did not stop after the last entry");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> $stable(v_s3) && $stable(tag_s3) && $stable(v_s1))
		else $error("pipe moved during output stall");

	a_fin_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && tag_s3.fin |-> tag_s3.ent < IDX_W'(ENTRIES))
		else $error("result entry out of range");
`endif
endmodule
`default_nettype wire

FILE: design/color_matrix_concat.sv
// color_matrix_concat: composes two 4x5 affine color matrices (outer times inner)
// load requests are taken one per cycle while the back is idle; a compute request
// runs 100 steps, five per product entry, on a single 32x32 multiplier, and emits
// one result per product entry; the back takes no new request until its last step issues
// asynchronous active-low reset clears all control; matrix stores are undefined until loaded
// depends on cmc_pkg, cmc_front, cmc_queue, cmc_back
`default_nettype none
module color_matrix_concat import cmc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [TDATA_W-1:0] s_tdata,  // entry_index, entry_value
	input  wire logic [TUSER_W-1:0] s_tuser,  // which_matrix, compute
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,  // result_index, result_value
	output logic                    m_tlast   // last
);
	logic push;
	logic full;
	logic pop;
	logic not_empty;
	cmd_t cmd;
	cmd_t head;

	cmc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.push     (push),
		.cmd      (cmd),
		.full     (full)
	);

	cmc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (cmd),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty)
	);

	cmc_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);
endmodule
`default_nettype wire
